[rtl/wfc_pkg.sv]
package wfc_pkg;

	localparam int ADDR_W          = 32;
	localparam int PORT_W          = 16;
	localparam int PKT_W           = 4;
	localparam int CNT_W           = 7;
	localparam int MIN_W           = 4;
	localparam int IN_DATA_W       = 2 * ADDR_W + 2 * PORT_W;
	localparam int OUT_DATA_W      = 8;
	localparam int DEF_FLOW_SLOTS  = 64;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [PKT_W-1:0] PKT_MAX         = '1;
	localparam logic [CNT_W-1:0] CNT_MAX         = '1;
	localparam logic [MIN_W-1:0] MIN_PACKETS_RST = MIN_W'(2);

	// direction-free flow key: each address pair and port pair stored as lower and higher value
	typedef struct packed {
		logic [PORT_W-1:0] port_hi;
		logic [PORT_W-1:0] port_lo;
		logic [ADDR_W-1:0] addr_hi;
		logic [ADDR_W-1:0] addr_lo;
	} key_t;

	typedef struct packed {
		logic last;
		key_t key;
	} item_t;

endpackage

[rtl/wfc_front.sv]
module wfc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [wfc_pkg::ADDR_W-1:0] from_addr,
	input  logic [wfc_pkg::ADDR_W-1:0] dst_addr,
	input  logic [wfc_pkg::PORT_W-1:0] src_port,
	input  logic [wfc_pkg::PORT_W-1:0] dst_port,
	input  logic            window_end,
	output wfc_pkg::item_t  head,
	output logic            head_valid,
	input  logic            pop
);
	import wfc_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	item_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [OCC_W-1:0]  occ_q;
	item_t             item;
	logic              push;

	// order each pair so both directions give the same key
	always_comb begin
		item.last = window_end;
		if (from_addr < dst_addr) begin
			item.key.addr_lo = from_addr;
			item.key.addr_hi = dst_addr;
		end else begin
			item.key.addr_lo = dst_addr;
			item.key.addr_hi = from_addr;
		end
		if (src_port < dst_port) begin
			item.key.port_lo = src_port;
			item.key.port_hi = dst_port;
		end else begin
			item.key.port_lo = dst_port;
			item.key.port_hi = src_port;
		end
	end

	assign in_ready   = (occ_q != OCC_W'(QUEUE_DEPTH));
	assign push       = in_valid && in_ready;
	assign head_valid = (occ_q != '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				occ_q <= occ_q + 1'b1;
			end else if (pop && !push) begin
				occ_q <= occ_q - 1'b1;
			end
		end
	end

endmodule

[rtl/wfc_back.sv]
module wfc_back #(
	parameter int FLOW_SLOTS = wfc_pkg::DEF_FLOW_SLOTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wfc_pkg::item_t                head,
	input  logic                          head_valid,
	output logic                          pop,
	input  logic [wfc_pkg::MIN_W-1:0]     min_packets,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wfc_pkg::OUT_DATA_W-1:0] out_data
);
	import wfc_pkg::*;

	localparam int IDX_W  = $clog2(FLOW_SLOTS);
	localparam int FILL_W = $clog2(FLOW_SLOTS + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	typedef struct packed {
		key_t             key;
		logic [PKT_W-1:0] pkts;
	} entry_t;

	entry_t              table_mem [FLOW_SLOTS];
	entry_t              rdata_q;
	logic                state_q;
	item_t               item_q;
	logic [FILL_W-1:0]   fill_q;
	logic [FILL_W-1:0]   idx_q;
	logic                pend_q;
	logic [IDX_W-1:0]    pidx_q;
	logic [CNT_W-1:0]    counted_q;
	logic                ovf_q;
	logic                out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic                hit;
	logic                miss;
	logic                finish;
	logic                issue;
	logic                room;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	entry_t              wr_data;
	logic [PKT_W-1:0]    need;
	logic                bump;
	logic [CNT_W-1:0]    counted_next;
	logic                ovf_next;

	assign pop = (state_q == ST_IDLE) && head_valid &&
		(!head.last || !out_valid_q || out_ready);

	assign hit    = (state_q == ST_SCAN) && pend_q && (rdata_q.key == item_q.key);
	assign miss   = (state_q == ST_SCAN) && !pend_q && (idx_q >= fill_q);
	assign finish = hit || miss;
	assign issue  = (state_q == ST_SCAN) && !hit && (idx_q < fill_q);
	assign room   = (fill_q < FILL_W'(FLOW_SLOTS));
	assign need   = (min_packets == '0) ? PKT_W'(1) : min_packets;

	// table update and window counters
	always_comb begin
		wr_en        = 1'b0;
		wr_addr      = pidx_q;
		wr_data.key  = item_q.key;
		wr_data.pkts = PKT_W'(1);
		bump         = 1'b0;
		ovf_next     = ovf_q;
		if (hit) begin
			if (rdata_q.pkts != PKT_MAX) begin
				wr_en        = 1'b1;
				wr_data.pkts = rdata_q.pkts + 1'b1;
				bump         = (wr_data.pkts == need);
			end
		end else if (miss) begin
			if (room) begin
				wr_en   = 1'b1;
				wr_addr = fill_q[IDX_W-1:0];
				bump    = (need == PKT_W'(1));
			end else begin
				ovf_next = 1'b1;
			end
		end
		counted_next = (bump && counted_q != CNT_MAX) ? counted_q + 1'b1 : counted_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_q <= table_mem[idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
		if (issue) begin
			pidx_q <= idx_q[IDX_W-1:0];
		end
		if (finish && item_q.last) begin
			out_data_q <= {ovf_next, counted_next};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			counted_q   <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
						pend_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					pend_q <= issue;
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (finish) begin
						state_q <= ST_IDLE;
						pend_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (finish) begin
				if (item_q.last) begin
					fill_q    <= '0;
					counted_q <= '0;
					ovf_q     <= 1'b0;
				end else begin
					if (miss && room) begin
						fill_q <= fill_q + 1'b1;
					end
					counted_q <= counted_next;
					ovf_q     <= ovf_next;
				end
			end

			if (finish && item_q.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[rtl/window_flow_counter.sv]
// each key is registered into the key queue; after a pop the lookup scans the stored slots,
// fill being the flows stored in the window (at most FLOW_SLOTS); the result is then registered
// throughput: one packet per lookup, set by the key table's single read port, one slot per cycle
// a two-entry queue takes packets while a lookup runs; results wait in an output register
// reset: asynchronous, active low; empties the queue and the table fill count, min_packets to 2
// no clearing pass: the fill count marks stored slots, so the table is usable right after reset
module window_flow_counter #(
	parameter int FLOW_SLOTS = wfc_pkg::DEF_FLOW_SLOTS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// packet headers
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// from_addr[31:0], dst_addr[63:32], src_port[79:64], dst_port[95:80]
	input  logic [wfc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// window_end
	input  logic                           s_axis_tlast,
	// window results
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// flow_count[6:0], table_overflow[7]
	output logic [wfc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// min_packets register
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wfc_pkg::MIN_W-1:0]      cfg_data
);
	import wfc_pkg::*;

	logic [MIN_W-1:0] min_packets_q;
	item_t            head;
	logic             head_valid;
	logic             pop;

	// configuration register, always ready for a transaction
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_packets_q <= MIN_PACKETS_RST;
		end else if (cfg_valid) begin
			min_packets_q <= cfg_data;
		end
	end

	// front: order the address and port pairs, queue the keys
	wfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.from_addr  (s_axis_tdata[ADDR_W-1:0]),
		.dst_addr   (s_axis_tdata[2*ADDR_W-1:ADDR_W]),
		.src_port   (s_axis_tdata[2*ADDR_W+PORT_W-1:2*ADDR_W]),
		.dst_port   (s_axis_tdata[2*ADDR_W+2*PORT_W-1:2*ADDR_W+PORT_W]),
		.window_end (s_axis_tlast),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	// back: scan the flow table, update counts, emit the window result
	wfc_back #(
		.FLOW_SLOTS (FLOW_SLOTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.min_packets (min_packets_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata)
	);

	// the back only takes a key the queue holds
	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty key queue");

	// a stalled front means the queue holds keys for the back
	a_stall_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> head_valid)
		else $error("front stalled with empty queue");

	// a waiting window result holds its data until taken
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("window result changed while stalled");

	// a window result only rises once a popped key's lookup has ended, never right after the pop
	a_result_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(pop))
		else $error("result raised in the cycle after a pop");

endmodule
